FILE: hdl/kr_pkg.sv
// ----------------------------------------------------------------------------
// kr_pkg
// Shared types, constants and helpers for the keyed record table.
// ----------------------------------------------------------------------------
package kr_pkg;

	localparam int TABLE_DEPTH = 32;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
	localparam int KEY_BYTES   = 16;
	localparam int KEY_W       = 128;
	localparam int TAG_W       = 32;
	localparam int STACK_DEPTH = 32;
	localparam int SP_W        = $clog2(STACK_DEPTH + 1);
	localparam int SIDX_W      = $clog2(STACK_DEPTH);
	localparam int OP_W        = 3;
	localparam int STATUS_W    = 2;
	localparam int OUT_IDX_W   = 5;

	localparam logic [KEY_W-1:0] KEY_MASK = {KEY_W{1'b1}} << (KEY_W - 8 * KEY_BYTES);

	localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NONE = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

	typedef enum logic [OP_W-1:0] {
		OP_APPEND = 3'd0,
		OP_FIND1  = 3'd1,
		OP_FINDALL = 3'd2,
		OP_DELETE = 3'd3,
		OP_SORT   = 3'd4,
		OP_DUMP   = 3'd5
	} op_t;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [TAG_W-1:0] tag;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic [IDX_W-1:0] lo;
		logic [IDX_W-1:0] hi;
	} bounds_t;

	typedef struct packed {
		logic [STATUS_W-1:0]  status;
		logic [OUT_IDX_W-1:0] index;
		entry_t               ent;
		logic                 last;
	} result_t;

	function automatic result_t mk_result(logic [STATUS_W-1:0] status,
			logic [CNT_W-1:0] idx, entry_t ent, logic last);
		result_t r;
		r.status = status;
		r.index  = OUT_IDX_W'(idx);
		r.ent    = ent;
		r.last   = last;
		return r;
	endfunction

endpackage

FILE: hdl/kr_req_if.sv
// ----------------------------------------------------------------------------
// kr_req_if
// Request channel: opcode, key words and payload tag.
// ----------------------------------------------------------------------------
interface kr_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  opcode;
	logic [63:0] key_high;
	logic [63:0] key_low;
	logic [31:0] payload_tag;

	modport source (output valid, opcode, key_high, key_low, payload_tag, input ready);
	modport sink   (input valid, opcode, key_high, key_low, payload_tag, output ready);
endinterface

FILE: hdl/kr_rsp_if.sv
// ----------------------------------------------------------------------------
// kr_rsp_if
// Result channel: status, reported entry and last marker.
// ----------------------------------------------------------------------------
interface kr_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [4:0]  entry_index;
	logic [63:0] found_key_high;
	logic [63:0] found_key_low;
	logic [31:0] found_payload;
	logic        last;

	modport source (output valid, status, entry_index, found_key_high, found_key_low,
		found_payload, last, input ready);
	modport sink   (input valid, status, entry_index, found_key_high, found_key_low,
		found_payload, last, output ready);
endinterface

FILE: hdl/kr_ram.sv
// ----------------------------------------------------------------------------
// kr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module kr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

FILE: hdl/kr_cmp.sv
// ----------------------------------------------------------------------------
// kr_cmp
// Shared 128-bit unsigned key comparator (equal and less-than).
// ----------------------------------------------------------------------------
module kr_cmp (
	input  logic [kr_pkg::KEY_W-1:0] a,
	input  logic [kr_pkg::KEY_W-1:0] b,
	output logic                     eq,
	output logic                     lt
);
	import kr_pkg::*;

	assign eq = (a == b);
	assign lt = (a < b);
endmodule

FILE: hdl/keyed_record_table_with_sort.sv
// ----------------------------------------------------------------------------
// keyed_record_table_with_sort
// Record table with append, find, find all, delete, dump and in-place
// quicksort, run by a sequencer around one table RAM and one comparator.
// ----------------------------------------------------------------------------
//  channel | dir | payload                                          | handshake
//  req     | in  | opcode, key_high, key_low, payload_tag           | valid/ready
//  rsp     | out | status, entry_index, found_key_*, found_payload, | valid/ready
//          |     | last                                             |
//
// Append writes the record at the table's end; find, find all, delete and
// dump scan the stored entries in turn, and delete then moves each later
// entry down one place. Sort partitions in place with O(n log n) compares
// on average. req.ready is high only while idle. Reset clears the count and
// control only; the table needs no clearing pass. A stalled rsp holds the
// sequencer at its next result.
module keyed_record_table_with_sort (
	input  logic   clk,
	input  logic   arst_n,
	kr_req_if.sink   req,
	kr_rsp_if.source rsp
);
	import kr_pkg::*;

	typedef enum logic [16:0] {
		S_IDLE     = 17'b00000000000000001,
		S_APPEND   = 17'b00000000000000010,
		S_SCAN_RD  = 17'b00000000000000100,
		S_SCAN_CHK = 17'b00000000000001000,
		S_FIN      = 17'b00000000000010000,
		S_SHIFT_RD = 17'b00000000000100000,
		S_SHIFT_WR = 17'b00000000001000000,
		S_POP      = 17'b00000000010000000,
		S_PIV      = 17'b00000000100000000,
		S_PRD      = 17'b00000001000000000,
		S_PCHK     = 17'b00000010000000000,
		S_SW_RA    = 17'b00000100000000000,
		S_SW_RB    = 17'b00001000000000000,
		S_SW_WA    = 17'b00010000000000000,
		S_SW_WB    = 17'b00100000000000000,
		S_PUSH1    = 17'b01000000000000000,
		S_PUSH2    = 17'b10000000000000000
	} state_t;

	state_t           state_q;
	op_t              op_q;
	logic [KEY_W-1:0] key_q;
	logic [TAG_W-1:0] tag_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] idx_q;
	logic             pend_v_q;
	entry_t           pend_q;
	logic [CNT_W-1:0] pidx_q;
	logic [KEY_W-1:0] pivot_q;
	logic [IDX_W-1:0] lo_q;
	logic [IDX_W-1:0] hi_q;
	logic [IDX_W-1:0] place_q;
	logic [IDX_W-1:0] sa_q;
	logic [IDX_W-1:0] sb_q;
	logic             fin_q;
	entry_t           tmp_q;
	bounds_t          stk_q [STACK_DEPTH];
	logic [SP_W-1:0]  sp_q;
	logic             ov_q;
	result_t          out_q;

	logic             emit_ok;
	logic             out_fire;
	logic             ram_we;
	logic             ram_re;
	logic [IDX_W-1:0] ram_waddr;
	logic [IDX_W-1:0] ram_raddr;
	entry_t           ram_wdata;
	logic [ENTRY_W-1:0] ram_rdata;
	entry_t           rd_ent;
	logic [KEY_W-1:0] cmp_b;
	logic             cmp_eq;
	logic             cmp_lt;
	bounds_t          top_b;
	logic [CNT_W-1:0] idx_nx;
	logic [IDX_W-1:0] llen;
	logic [IDX_W-1:0] rlen;
	bounds_t          left_b;
	bounds_t          right_b;
	logic             big_left;
	entry_t           zero_ent;

	assign req.ready = (state_q == S_IDLE);
	assign rsp.valid = ov_q;
	assign rsp.status = out_q.status;
	assign rsp.entry_index = out_q.index;
	assign rsp.found_key_high = out_q.ent.key[KEY_W-1:64];
	assign rsp.found_key_low = out_q.ent.key[63:0];
	assign rsp.found_payload = out_q.ent.tag;
	assign rsp.last = out_q.last;

	assign emit_ok = !ov_q || rsp.ready;
	// a result is loaded into the output register this cycle
	assign out_fire = emit_ok && (state_q == S_APPEND || state_q == S_FIN ||
		(state_q == S_SCAN_CHK && (op_q == OP_DUMP || cmp_eq) &&
		(op_q == OP_FIND1 || op_q == OP_DELETE || pend_v_q)));
	assign rd_ent = entry_t'(ram_rdata);
	assign cmp_b = (op_q == OP_SORT) ? pivot_q : key_q;
	assign top_b = stk_q[SIDX_W'(sp_q - SP_W'(1))];
	assign idx_nx = idx_q + CNT_W'(1);
	assign llen = place_q - lo_q;
	assign rlen = hi_q - place_q;
	assign big_left = llen > rlen;
	assign left_b = '{lo: lo_q, hi: place_q - IDX_W'(1)};
	assign right_b = '{lo: place_q + IDX_W'(1), hi: hi_q};
	assign zero_ent = '0;

	kr_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_DEPTH)) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	kr_cmp u_cmp (
		.a  (rd_ent.key),
		.b  (cmp_b),
		.eq (cmp_eq),
		.lt (cmp_lt)
	);

	always_comb begin
		ram_we = 1'b0;
		ram_re = 1'b0;
		ram_waddr = idx_q[IDX_W-1:0];
		ram_raddr = idx_q[IDX_W-1:0];
		ram_wdata = rd_ent;
		unique case (state_q)
			S_APPEND: begin
				ram_we = emit_ok && (cnt_q < CNT_W'(TABLE_DEPTH));
				ram_waddr = cnt_q[IDX_W-1:0];
				ram_wdata = '{key: key_q, tag: tag_q};
			end
			S_SCAN_RD: ram_re = (idx_q != cnt_q);
			S_SHIFT_RD: begin
				ram_re = (idx_nx < cnt_q);
				ram_raddr = idx_nx[IDX_W-1:0];
			end
			S_SHIFT_WR: ram_we = 1'b1;
			S_POP: begin
				ram_re = (sp_q != '0) && (top_b.lo < top_b.hi);
				ram_raddr = top_b.hi;
			end
			S_PRD: ram_re = (idx_q[IDX_W-1:0] != hi_q);
			S_SW_RA: begin
				ram_re = 1'b1;
				ram_raddr = sa_q;
			end
			S_SW_RB: begin
				ram_re = 1'b1;
				ram_raddr = sb_q;
			end
			S_SW_WA: begin
				ram_we = 1'b1;
				ram_waddr = sa_q;
			end
			S_SW_WB: begin
				ram_we = 1'b1;
				ram_waddr = sb_q;
				ram_wdata = tmp_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			sp_q <= '0;
			ov_q <= 1'b0;
			pend_v_q <= 1'b0;
		end else begin
			if (out_fire) begin
				ov_q <= 1'b1;
			end else if (rsp.ready) begin
				ov_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						op_q <= op_t'(req.opcode);
						key_q <= {req.key_high, req.key_low} & KEY_MASK;
						tag_q <= req.payload_tag;
						idx_q <= '0;
						pend_v_q <= 1'b0;
						unique case (req.opcode)
							OP_APPEND: state_q <= S_APPEND;
							OP_FIND1, OP_FINDALL, OP_DELETE, OP_DUMP: state_q <= S_SCAN_RD;
							OP_SORT: begin
								if (cnt_q < CNT_W'(2)) begin
									state_q <= S_FIN;
								end else begin
									stk_q[0] <= '{lo: '0, hi: IDX_W'(cnt_q - CNT_W'(1))};
									sp_q <= SP_W'(1);
									state_q <= S_POP;
								end
							end
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_APPEND: begin
					if (emit_ok) begin
						if (cnt_q >= CNT_W'(TABLE_DEPTH)) begin
							out_q <= mk_result(ST_FULL, '0, zero_ent, 1'b1);
						end else begin
							out_q <= mk_result(ST_OK, cnt_q, '{key: key_q, tag: tag_q}, 1'b1);
							cnt_q <= cnt_q + CNT_W'(1);
						end
						state_q <= S_IDLE;
					end
				end
				S_SCAN_RD: state_q <= (idx_q == cnt_q) ? S_FIN : S_SCAN_CHK;
				S_SCAN_CHK: begin
					if (op_q == OP_DUMP || cmp_eq) begin
						unique case (op_q)
							OP_FIND1, OP_DELETE: begin
								if (emit_ok) begin
									out_q <= mk_result(ST_OK, idx_q, rd_ent, 1'b1);
									state_q <= (op_q == OP_DELETE) ? S_SHIFT_RD : S_IDLE;
								end
							end
							default: begin
								if (!pend_v_q || emit_ok) begin
									if (pend_v_q) begin
										out_q <= mk_result(ST_OK, pidx_q, pend_q, 1'b0);
									end
									pend_v_q <= 1'b1;
									pend_q <= rd_ent;
									pidx_q <= idx_q;
									idx_q <= idx_nx;
									state_q <= S_SCAN_RD;
								end
							end
						endcase
					end else begin
						idx_q <= idx_nx;
						state_q <= S_SCAN_RD;
					end
				end
				S_FIN: begin
					if (emit_ok) begin
						if (pend_v_q) begin
							out_q <= mk_result(ST_OK, pidx_q, pend_q, 1'b1);
						end else if (op_q == OP_SORT) begin
							out_q <= mk_result(ST_OK, '0, zero_ent, 1'b1);
						end else begin
							out_q <= mk_result(ST_NONE, '0, zero_ent, 1'b1);
						end
						state_q <= S_IDLE;
					end
				end
				S_SHIFT_RD: begin
					if (idx_nx < cnt_q) begin
						state_q <= S_SHIFT_WR;
					end else begin
						cnt_q <= cnt_q - CNT_W'(1);
						state_q <= S_IDLE;
					end
				end
				S_SHIFT_WR: begin
					idx_q <= idx_nx;
					state_q <= S_SHIFT_RD;
				end
				S_POP: begin
					if (sp_q == '0) begin
						state_q <= S_FIN;
					end else begin
						sp_q <= sp_q - SP_W'(1);
						lo_q <= top_b.lo;
						hi_q <= top_b.hi;
						if (top_b.lo < top_b.hi) begin
							idx_q <= CNT_W'(top_b.lo);
							place_q <= top_b.lo;
							state_q <= S_PIV;
						end
					end
				end
				S_PIV: begin
					pivot_q <= rd_ent.key;
					state_q <= S_PRD;
				end
				S_PRD: begin
					if (idx_q[IDX_W-1:0] == hi_q) begin
						sa_q <= hi_q;
						sb_q <= place_q;
						fin_q <= 1'b1;
						state_q <= S_SW_RA;
					end else begin
						state_q <= S_PCHK;
					end
				end
				S_PCHK: begin
					if (cmp_lt) begin
						sa_q <= idx_q[IDX_W-1:0];
						sb_q <= place_q;
						fin_q <= 1'b0;
						state_q <= S_SW_RA;
					end else begin
						idx_q <= idx_nx;
						state_q <= S_PRD;
					end
				end
				S_SW_RA: state_q <= S_SW_RB;
				S_SW_RB: begin
					tmp_q <= rd_ent;
					state_q <= S_SW_WA;
				end
				S_SW_WA: state_q <= S_SW_WB;
				S_SW_WB: begin
					if (fin_q) begin
						state_q <= S_PUSH1;
					end else begin
						place_q <= place_q + IDX_W'(1);
						idx_q <= idx_nx;
						state_q <= S_PRD;
					end
				end
				S_PUSH1: begin
					if (sp_q < SP_W'(STACK_DEPTH)) begin
						if (big_left && llen > IDX_W'(1)) begin
							stk_q[sp_q[SIDX_W-1:0]] <= left_b;
							sp_q <= sp_q + SP_W'(1);
						end else if (!big_left && rlen > IDX_W'(1)) begin
							stk_q[sp_q[SIDX_W-1:0]] <= right_b;
							sp_q <= sp_q + SP_W'(1);
						end
					end
					state_q <= S_PUSH2;
				end
				S_PUSH2: begin
					if (sp_q < SP_W'(STACK_DEPTH)) begin
						if (big_left && rlen > IDX_W'(1)) begin
							stk_q[sp_q[SIDX_W-1:0]] <= right_b;
							sp_q <= sp_q + SP_W'(1);
						end else if (!big_left && llen > IDX_W'(1)) begin
							stk_q[sp_q[SIDX_W-1:0]] <= left_b;
							sp_q <= sp_q + SP_W'(1);
						end
					end
					state_q <= S_POP;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(TABLE_DEPTH))
		else $error("entry count exceeds table depth");

	a_sp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= SP_W'(STACK_DEPTH))
		else $error("bounds stack overflow");

	a_place_le_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PRD) |-> (CNT_W'(place_q) <= idx_q))
		else $error("partition store point passed scan index");

	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && req.valid && req.opcode == OP_APPEND) |=>
		(state_q == S_APPEND))
		else $error("append did not enter append step");
endmodule
